// File: sv/mlt_pkg.sv
package mlt_pkg;

	// Default table depth.
	localparam int SLOTS_DEF = 16;

	// Field widths fixed by the word format.
	localparam int OP_W      = 3;
	localparam int SLOT_W    = 4;
	localparam int CHAN_W    = 8;
	localparam int SPLIT_W   = 5;

	localparam logic [SPLIT_W-1:0] SPLIT_RESET  = 5'd8;
	localparam logic [CHAN_W-1:0]  CHAN_INVALID = 8'hFF;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_FLUSH     = 3'd0;
	localparam logic [OP_W-1:0] OP_BIND      = 3'd1;
	localparam logic [OP_W-1:0] OP_ALLOC     = 3'd2;
	localparam logic [OP_W-1:0] OP_LOOK_USED = 3'd3;
	localparam logic [OP_W-1:0] OP_LOOK_ANY  = 3'd4;

	typedef struct packed {
		logic              port;
		logic [CHAN_W-1:0] channel;
		logic [SLOT_W-1:0] slot;
		logic [OP_W-1:0]   op;
	} mlt_req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot_index;
		logic              found;
	} mlt_res_t;

endpackage

// File: sv/mlt_engine.sv
module mlt_engine #(
	parameter int SLOTS = mlt_pkg::SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [mlt_pkg::SPLIT_W-1:0]     split,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  mlt_pkg::mlt_req_t               req,
	output logic                            res_valid,
	input  logic                            res_ready,
	output mlt_pkg::mlt_res_t               res
);

	localparam int AW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW  = $clog2(SLOTS + 1);
	localparam int WW  = (CW > mlt_pkg::SPLIT_W) ? CW : mlt_pkg::SPLIT_W;
	localparam int SW2 = (CW > mlt_pkg::SLOT_W) ? CW : mlt_pkg::SLOT_W;
	localparam int XW  = (AW > mlt_pkg::SLOT_W) ? AW : mlt_pkg::SLOT_W;
	localparam int EW  = 1 + mlt_pkg::CHAN_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q;

	// Table storage: in-use bit and channel per slot. A slot whose valid bit
	// is clear reads as free with an invalid channel.
	logic [EW-1:0]    mem [SLOTS];
	logic [SLOTS-1:0] valid_q;

	logic              is_alloc_q;
	logic              is_any_q;
	logic [mlt_pkg::CHAN_W-1:0] chan_q;
	logic              port_q;
	logic [CW-1:0]     addr_q;
	logic [CW-1:0]     hi_q;
	mlt_pkg::mlt_res_t res_q;

	logic              vld_s1;
	logic              last_s1;
	logic [AW-1:0]     idx_s1;
	logic              ent_vld_s1;
	logic [EW-1:0]     ent_s1;

	logic [WW-1:0]     split_w;
	logic [WW-1:0]     split_c;
	logic [SW2-1:0]    slot_w;
	logic              slot_ok;
	logic [AW-1:0]     wr_addr;
	logic              issue;
	logic              used_s1;
	logic [mlt_pkg::CHAN_W-1:0] chan_s1;
	logic              port_s1;
	logic              hit_s1;
	logic [XW-1:0]     idx_x;
	logic              accept;

	assign split_w = WW'(split);
	assign split_c = (split_w > WW'(SLOTS)) ? WW'(SLOTS) : split_w;
	assign slot_w  = SW2'(req.slot);
	assign slot_ok = slot_w < SW2'(SLOTS);
	assign wr_addr = slot_w[AW-1:0];
	assign accept  = req_valid && req_ready;
	assign issue   = (state_q == ST_SCAN) && (addr_q < hi_q);

	assign used_s1 = ent_vld_s1 && ent_s1[EW-1];
	assign chan_s1 = ent_vld_s1 ? ent_s1[mlt_pkg::CHAN_W-1:0] : mlt_pkg::CHAN_INVALID;
	assign port_s1 = WW'(idx_s1) >= split_c;
	assign hit_s1  = is_alloc_q ? !used_s1
		: ((is_any_q || used_s1) && (chan_s1 == chan_q) && (port_s1 == port_q));
	assign idx_x   = XW'(idx_s1);

	assign req_ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (accept && req.op == mlt_pkg::OP_BIND && slot_ok) begin
			mem[wr_addr] <= {1'b1, req.channel};
		end
		if (issue) begin
			ent_s1 <= mem[addr_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (accept && slot_ok) begin
			if (req.op == mlt_pkg::OP_BIND) begin
				valid_q[wr_addr] <= 1'b1;
			end else if (req.op == mlt_pkg::OP_FLUSH) begin
				valid_q[wr_addr] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			ent_vld_s1 <= valid_q[addr_q[AW-1:0]];
			idx_s1     <= addr_q[AW-1:0];
			last_s1    <= (addr_q + CW'(1)) == hi_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_alloc_q <= (req.op == mlt_pkg::OP_ALLOC);
			is_any_q   <= (req.op == mlt_pkg::OP_LOOK_ANY);
			chan_q     <= req.channel;
			port_q     <= req.port;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vld_s1  <= 1'b0;
			addr_q  <= '0;
			hi_q    <= '0;
			res_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					vld_s1 <= 1'b0;
					if (accept) begin
						case (req.op)
							mlt_pkg::OP_FLUSH, mlt_pkg::OP_BIND: begin
								res_q.found      <= slot_ok;
								res_q.slot_index <= slot_ok ? req.slot : '0;
								state_q          <= ST_DONE;
							end
							mlt_pkg::OP_ALLOC: begin
								if (req.port) begin
									addr_q <= CW'(split_c);
									hi_q   <= CW'(SLOTS);
								end else begin
									addr_q <= '0;
									hi_q   <= CW'(split_c);
								end
								// An empty range fails at once.
								if ((req.port && split_c == WW'(SLOTS)) ||
								    (!req.port && split_c == '0)) begin
									res_q   <= '0;
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							mlt_pkg::OP_LOOK_USED, mlt_pkg::OP_LOOK_ANY: begin
								addr_q  <= '0;
								hi_q    <= CW'(SLOTS);
								state_q <= ST_SCAN;
							end
							default: begin
								res_q   <= '0;
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (vld_s1 && hit_s1) begin
						res_q.found      <= 1'b1;
						res_q.slot_index <= idx_x[mlt_pkg::SLOT_W-1:0];
						vld_s1           <= 1'b0;
						state_q          <= ST_DONE;
					end else if (vld_s1 && last_s1) begin
						res_q   <= '0;
						vld_s1  <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						vld_s1 <= issue;
						if (issue) begin
							addr_q <= addr_q + CW'(1);
						end
					end
				end
				ST_DONE: begin
					vld_s1 <= 1'b0;
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					vld_s1  <= 1'b0;
				end
			endcase
		end
	end

	// The scan address never runs past the end of its range.
	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> addr_q <= hi_q)
		else $error("scan address beyond range end");

	// Read data is only examined after a read issued during a scan.
	a_s1_origin: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> $past(state_q == ST_SCAN))
		else $error("read stage valid outside a scan");

	// A scan never reports a slot outside the table.
	a_found_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && vld_s1 && hit_s1) |-> WW'(idx_s1) < WW'(SLOTS))
		else $error("hit on slot beyond table");

	// The table is written only while idle.
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q != $past(valid_q)) |-> $past(state_q == ST_IDLE))
		else $error("table changed outside idle");

endmodule

// File: sv/mux_link_table_top.sv
// Flush, bind and unknown operations: no table scan, straight to the result register.
// Allocate and lookup: one slot read per cycle from the table memory until a hit or the
// end of the range, then the result is registered; the block takes one item at a time.
// A new input word is taken while an earlier result still waits in the output register.
// Reset (arst_n low, asynchronous) frees every slot, marks all channels invalid and sets
// the split register to 8; no clearing pass is needed, per-slot valid bits do that.
module mux_link_table_top #(
	parameter int SLOTS = mlt_pkg::SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: split point between the two serial ports.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data,
	// Input words.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // op[2:0], slot[6:3], channel[14:7], port[15]
	// Result words.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata   // found[0], slot_index[4:1], zero[7:5]
);

	logic [mlt_pkg::SPLIT_W-1:0] split_q;
	mlt_pkg::mlt_req_t           req;
	mlt_pkg::mlt_res_t           res;
	logic                        res_valid;
	logic                        res_ready;
	logic                        out_vld_q;
	mlt_pkg::mlt_res_t           out_res_q;

	// The split register is always writable; the user writes it only while idle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_q <= mlt_pkg::SPLIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			split_q <= cfg_data;
		end
	end

	// Unpack the input word.
	assign req.op      = s_axis_tdata[2:0];
	assign req.slot    = s_axis_tdata[6:3];
	assign req.channel = s_axis_tdata[14:7];
	assign req.port    = s_axis_tdata[15];

	mlt_engine #(
		.SLOTS(SLOTS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.split    (split_q),
		.req_valid(s_axis_tvalid),
		.req_ready(s_axis_tready),
		.req      (req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// Output register: it holds a finished result so the engine can move on.
	assign res_ready = !out_vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_res_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {3'b000, out_res_q.slot_index, out_res_q.found};

endmodule

// File: verif/link_table_checker.sv
`timescale 1ns / 1ps

module link_table_checker #(
	parameter int SLOTS = mlt_pkg::SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [4:0]  cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // op[2:0], slot[6:3], channel[14:7], port[15]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [7:0]  m_axis_tdata,  // found[0], slot_index[4:1], zero[7:5]
	input  logic        run_done,
	output int          pending,
	output int          fail_count
);
	import mlt_pkg::*;

	logic              link_used [SLOTS];
	logic [CHAN_W-1:0] link_chan [SLOTS];
	logic [SPLIT_W-1:0] split_reg;
	mlt_res_t          expected_results [$];
	int                err_total = 0;
	bit                leftover_checked = 1'b0;

	// Applies one operation to the shadow table and returns the result word it should produce.
	function automatic mlt_res_t apply_link_op(input mlt_req_t req);
		mlt_res_t res;
		int boundary;
		int first;
		int limit;
		res = '0;
		boundary = (int'(split_reg) > SLOTS) ? SLOTS : int'(split_reg);
		case (req.op)
			OP_FLUSH, OP_BIND: begin
				if (int'(req.slot) < SLOTS) begin
					link_used[req.slot] = (req.op == OP_BIND);
					link_chan[req.slot] = (req.op == OP_BIND) ? req.channel : CHAN_INVALID;
					res.found = 1'b1;
					res.slot_index = req.slot;
				end
			end
			OP_ALLOC: begin
				first = req.port ? boundary : 0;
				limit = req.port ? SLOTS : boundary;
				// Scanning downward leaves the lowest hit in res.
				for (int i = limit - 1; i >= first; i--) begin
					if (!link_used[i]) begin
						res.found = 1'b1;
						res.slot_index = SLOT_W'(i);
					end
				end
			end
			OP_LOOK_USED, OP_LOOK_ANY: begin
				for (int i = SLOTS - 1; i >= 0; i--) begin
					if ((req.op == OP_LOOK_ANY || link_used[i]) && link_chan[i] == req.channel
							&& ((i >= boundary) == req.port)) begin
						res.found = 1'b1;
						res.slot_index = SLOT_W'(i);
					end
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		mlt_res_t got;
		mlt_res_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				link_used[i] = 1'b0;
				link_chan[i] = CHAN_INVALID;
			end
			split_reg = SPLIT_RESET;
			expected_results.delete();
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				split_reg = cfg_data;
			// A result word always leaves after its input word is taken, so pop before push.
			if (m_axis_tvalid && m_axis_tready) begin
				got = mlt_res_t'(m_axis_tdata[4:0]);
				if (expected_results.size() == 0) begin
					$error("result word with nothing expected: found %0d slot_index %0d",
						got.found, got.slot_index);
					err_total++;
				end else begin
					want = expected_results.pop_front();
					if (got.found !== want.found) begin
						$error("found: expected %0d, actual %0d", want.found, got.found);
						err_total++;
					end
					if (got.slot_index !== want.slot_index) begin
						$error("slot_index: expected %0d, actual %0d",
							want.slot_index, got.slot_index);
						err_total++;
					end
					if (m_axis_tdata[7:5] !== 3'b000) begin
						$error("zero pad: expected 0, actual %0d", m_axis_tdata[7:5]);
						err_total++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(apply_link_op(mlt_req_t'(s_axis_tdata)));
			if (run_done && !leftover_checked) begin
				leftover_checked = 1'b1;
				if (expected_results.size() != 0) begin
					$error("%0d expected result words never arrived", expected_results.size());
					err_total++;
				end
			end
			pending <= expected_results.size();
			fail_count <= err_total;
		end
	end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import mlt_pkg::*;

	localparam int SLOTS           = SLOTS_DEF;
	localparam int PHASES          = 10;
	localparam int WORDS_PER_PHASE = 104;
	localparam int MAX_GAP         = 12;
	localparam int HOLD_CYCLES     = 400;
	// No correct run goes this long without a handshake: the long output hold-off is
	// the worst case and this is several times that.
	localparam int WATCHDOG_LIMIT  = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [4:0]  cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;  // op[2:0], slot[6:3], channel[14:7], port[15]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;       // found[0], slot_index[4:1], zero[7:5]
	logic        run_done = 1'b0;
	int          pending;
	int          fail_count;

	// Shared pacing controls. When no_idle is set, neither side inserts gaps.
	// rx_hold_req asks the result sink for one long hold-off.
	bit          no_idle = 1'b0;
	bit          rx_hold_req = 1'b0;
	int          words_sent = 0;
	int          split_writes = 0;
	int          results_seen = 0;
	int          stall_cycles = 0;

	mux_link_table_top #(.SLOTS(SLOTS)) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// The checker watches all three channels, keeps its own copy of the table and
	// compares every result word against its prediction.
	link_table_checker #(.SLOTS(SLOTS)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.run_done      (run_done),
		.pending       (pending),
		.fail_count    (fail_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Number of idle cycles one side waits before its next word.
	function automatic int idle_gap();
		return no_idle ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	function automatic mlt_req_t link_op(input logic [OP_W-1:0] op, input int slot,
			input logic [CHAN_W-1:0] channel, input logic port);
		mlt_req_t req;
		req.op = op;
		req.slot = SLOT_W'(slot);
		req.channel = channel;
		req.port = port;
		return req;
	endfunction

	// Random operation word. Channels are mostly drawn from a small pool so that
	// lookups actually hit bound slots; the rest is the invalid channel or noise.
	// Bind-heavy phases fill the table so that allocate runs out of free slots.
	function automatic mlt_req_t random_link_op(input bit bind_heavy);
		mlt_req_t req;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < (bind_heavy ? 10 : 15))
			req.op = OP_FLUSH;
		else if (pick < (bind_heavy ? 55 : 45))
			req.op = OP_BIND;
		else if (pick < 70)
			req.op = OP_ALLOC;
		else if (pick < 83)
			req.op = OP_LOOK_USED;
		else if (pick < 96)
			req.op = OP_LOOK_ANY;
		else
			req.op = OP_W'($urandom_range(5, 7));
		req.slot = SLOT_W'($urandom_range(0, SLOTS - 1));
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			case ($urandom_range(0, 3))
				0: req.channel = 8'h00;
				1: req.channel = 8'h01;
				2: req.channel = 8'h5A;
				default: req.channel = 8'hFE;
			endcase
		end else if (pick < 7) begin
			req.channel = CHAN_INVALID;
		end else begin
			req.channel = CHAN_W'($urandom_range(0, 255));
		end
		req.port = 1'($urandom_range(0, 1));
		return req;
	endfunction

	// Offers one word after a random gap and returns once ready reads high after an edge.
	// Valid is only lowered when a gap follows, so back-to-back words keep it high.
	task automatic send_word(input mlt_req_t req);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= req;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		words_sent++;
	endtask

	// Waits until every expected result word has come back.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// The split register may only change while the table is idle. Every word makes
	// exactly one result, so once nothing is pending the block has finished; the
	// extra pause covers one full table scan anyway.
	task automatic write_split(input logic [SPLIT_W-1:0] value);
		drain_results();
		repeat (SLOTS + 4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		split_writes++;
	endtask

	// Result sink. It idles at random between words, and once on request it holds
	// ready low for a long stretch so the block backs up and stalls its input.
	initial begin : result_sink
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = idle_gap();
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	// Watchdog: a long run of cycles without any handshake means the block hung.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (m_axis_tvalid && m_axis_tready)
			results_seen <= results_seen + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("mux_link_table_top verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		int phase;
		int n;
		logic [SPLIT_W-1:0] split_value;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words against the reset split of 8. A search over all slots for
		// the invalid channel hits free slots, while a search over used slots
		// misses. Then binds on both sides of the split, lookups that hit and miss
		// on port, flushes at both ends and the unused op codes, fields all high or all low.
		send_word(link_op(OP_LOOK_ANY, 0, CHAN_INVALID, 1'b0));
		send_word(link_op(OP_LOOK_ANY, 0, CHAN_INVALID, 1'b1));
		send_word(link_op(OP_LOOK_USED, 0, CHAN_INVALID, 1'b0));
		send_word(link_op(OP_ALLOC, 0, 8'h00, 1'b0));
		send_word(link_op(OP_ALLOC, 0, 8'h00, 1'b1));
		send_word(link_op(OP_BIND, 0, 8'h00, 1'b0));
		send_word(link_op(OP_BIND, 8, 8'h5A, 1'b1));
		send_word(link_op(OP_BIND, 15, CHAN_INVALID, 1'b1));
		send_word(link_op(OP_ALLOC, 0, 8'h00, 1'b0));
		send_word(link_op(OP_ALLOC, 0, 8'h00, 1'b1));
		send_word(link_op(OP_LOOK_USED, 0, 8'h00, 1'b0));
		send_word(link_op(OP_LOOK_USED, 0, 8'h5A, 1'b1));
		send_word(link_op(OP_LOOK_USED, 0, 8'h5A, 1'b0));
		send_word(link_op(OP_LOOK_USED, 0, CHAN_INVALID, 1'b1));
		send_word(link_op(OP_FLUSH, 0, 8'h00, 1'b0));
		send_word(link_op(OP_FLUSH, 15, CHAN_INVALID, 1'b1));
		send_word(link_op(OP_LOOK_USED, 0, 8'h00, 1'b0));
		send_word(link_op(3'd5, 15, CHAN_INVALID, 1'b1));
		send_word(link_op(3'd6, 0, 8'h00, 1'b0));
		send_word(link_op(3'd7, 15, CHAN_INVALID, 1'b1));

		// Random phases, each under its own split setting. The table carries over
		// from phase to phase, so a slot's port changes with the split. The list
		// includes an empty first port, an empty second port and values past the
		// end of the table.
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: split_value = 5'd0;
				1: split_value = 5'd16;
				2: split_value = 5'd31;
				3: split_value = 5'd1;
				4: split_value = 5'd15;
				5: split_value = 5'd17;
				6: split_value = SPLIT_RESET;
				7: split_value = SPLIT_W'($urandom_range(0, 16));
				8: split_value = SPLIT_W'($urandom_range(0, 31));
				default: split_value = 5'd16;
			endcase
			write_split(split_value);
			// One phase runs with no gaps on either side.
			no_idle = (phase == 3);
			for (n = 0; n < WORDS_PER_PHASE; n++) begin
				// Partway through one phase, the sink stops taking results while
				// words keep coming.
				if (phase == 5 && n == 10)
					rx_hold_req = 1'b1;
				send_word(random_link_op(phase[0]));
			end
		end
		no_idle = 1'b0;

		drain_results();
		repeat (SLOTS + 8) @(posedge clk);
		run_done <= 1'b1;
		repeat (3) @(posedge clk);

		$display("Run covered %0d operation words and %0d result words over %0d split settings.",
			words_sent, results_seen, split_writes + 1);
		$display("Output was held off once for %0d cycles while input kept arriving.",
			HOLD_CYCLES);
		if (fail_count == 0)
			$display("mux_link_table_top verification clean");
		else
			$display("mux_link_table_top verification failed");
		$finish;
	end

endmodule
